// ===== rtl/lazy_segment_tree_range_add_sum_defines.svh =====
// ---------------------------------------------------------------------------
// Lazy segment tree assertion macros
// Shared concurrent assertion forms for the range add / range sum block.
// ---------------------------------------------------------------------------
`ifndef LAZY_SEGMENT_TREE_RANGE_ADD_SUM_DEFINES_SVH
`define LAZY_SEGMENT_TREE_RANGE_ADD_SUM_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LSTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsts: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define LSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsts: next-cycle check failed");

`endif

// ===== rtl/lsts_pkg.sv =====
// ---------------------------------------------------------------------------
// Lazy segment tree package
// Field widths, mode codes and the sequencer state type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsts_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int CNT_W            = 11;
  localparam int IN_W             = 10;
  localparam int VAL_W            = 32;
  localparam int SUM_W            = 64;
  localparam int IN_TDATA_W       = 56;
  localparam int OUT_TDATA_W      = 64;

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_SUM = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_CALC,
    ST_APPLY,
    ST_CRD0,
    ST_CRD1,
    ST_CWR1,
    ST_RET,
    ST_DONE
  } lsts_state_t;

endpackage

`default_nettype wire

// ===== rtl/lazy_segment_tree_range_add_sum.sv =====
// ---------------------------------------------------------------------------
// Lazy segment tree, range add / range sum
// Node sums and pending adds live in two synchronous RAMs; a depth-first
// sequencer with a small frame stack walks the tree one node at a time.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | slave     | in_tvalid/in_tready | tdata left,right,value; tuser mode
//  out_    | master    | out_tvalid/out_tready | tdata range_sum; tuser range_error
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_data element_count
//
//  Each node visit steps through read, settle, write back and return, with
//  extra child read and write steps when pending adds are pushed to
//  children; a rejected range skips the tree walk.
//  After reset a clearing pass writes zeros to all 2*2^clog2(MAX_ELEMENTS)
//  entries with in_tready low.
//  One item is worked at a time; a result waiting in the output register
//  does not block the next accept, only the next result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lazy_segment_tree_range_add_sum_defines.svh"

module lazy_segment_tree_range_add_sum #(
  parameter int MAX_ELEMENTS = lsts_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: left[9:0], right[19:10], value[51:20], zero fill
  input  wire logic [lsts_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: mode[0]
  input  wire logic                               in_tuser,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // out_tdata: range_sum[63:0]
  output logic [lsts_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // out_tuser: range_error[0]
  output logic                                    out_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic [lsts_pkg::CNT_W-1:0]         cfg_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready
);
  import lsts_pkg::*;

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int AW    = IDX_W + 1;
  localparam int DEPTH = 1 << AW;
  localparam int STK   = IDX_W + 1;
  localparam int LV_W  = $clog2(STK);
  localparam int LEN_W = IDX_W + 1;

  // Storage
  logic [SUM_W-1:0] sum_mem  [DEPTH];
  logic [SUM_W-1:0] pend_mem [DEPTH];

  // Control and datapath registers
  lsts_state_t       state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              mode_r, mode_nxt;
  logic [IN_W-1:0]   l_r, l_nxt, r_r, r_nxt;
  logic [SUM_W-1:0]  v_r, v_nxt;
  logic [AW-1:0]     cur_k_r, cur_k_nxt;
  logic [IDX_W-1:0]  cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;
  logic [SUM_W-1:0]  cur_carry_r, cur_carry_nxt;
  logic [LV_W-1:0]   lvl_r, lvl_nxt;
  logic              cls_out_r, cls_out_nxt, cls_full_r, cls_full_nxt;
  logic [SUM_W-1:0]  d_r, d_nxt, osum_r, osum_nxt, ret_r, ret_nxt;
  logic [SUM_W-1:0]  res_sum_r, res_sum_nxt;
  logic              res_err_r, res_err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_sum_r, out_sum_nxt;
  logic              out_err_r, out_err_nxt;

  // Frame stack of partially covered ancestors
  logic [AW-1:0]     stk_k_r     [STK];
  logic [IDX_W-1:0]  stk_lo_r    [STK];
  logic [IDX_W-1:0]  stk_hi_r    [STK];
  logic [SUM_W-1:0]  stk_carry_r [STK];
  logic [SUM_W-1:0]  stk_acc_r   [STK];
  logic              stk_right_r [STK];

  // Memory ports
  logic              sum_we, pend_we;
  logic [AW-1:0]     sum_wa, pend_wa, sum_ra, pend_ra;
  logic [SUM_W-1:0]  sum_wd, pend_wd, sum_rd_r, pend_rd_r;

  // Stack control
  logic              stk_push, stk_upd;
  logic [LV_W-1:0]   stk_wi;
  logic [SUM_W-1:0]  stk_upd_acc;

  // Combinational helpers
  logic              in_fire;
  logic [31:0]       n_eff;
  logic [IN_W-1:0]   in_left, in_right;
  logic [VAL_W-1:0]  in_value;
  logic [LEN_W-1:0]  cur_len;
  logic [IDX_W-1:0]  cur_mid;
  logic              c_out, c_full, c_partial, c_leaf;
  logic [SUM_W-1:0]  pe, new_sum, acc_sum;
  logic [LV_W-1:0]   par_i;
  logic              at_root;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_err_r;

  assign in_left  = in_tdata[IN_W-1:0];
  assign in_right = in_tdata[2*IN_W-1:IN_W];
  assign in_value = in_tdata[2*IN_W+VAL_W-1:2*IN_W];

  // Clamp the element count to 1 .. MAX_ELEMENTS
  always_comb begin
    if (cnt_r == '0) begin
      n_eff = 32'd1;
    end else if (32'(cnt_r) > 32'(MAX_ELEMENTS)) begin
      n_eff = 32'(MAX_ELEMENTS);
    end else begin
      n_eff = 32'(cnt_r);
    end
  end

  // Geometry and classification of the current node
  assign cur_len   = LEN_W'({1'b0, cur_hi_r} - {1'b0, cur_lo_r} + LEN_W'(1));
  assign cur_mid   = IDX_W'(({1'b0, cur_lo_r} + {1'b0, cur_hi_r}) >> 1);
  assign c_out     = (32'(r_r) < 32'(cur_lo_r)) || (32'(l_r) > 32'(cur_hi_r));
  assign c_full    = !c_out && (32'(l_r) <= 32'(cur_lo_r)) && (32'(cur_hi_r) <= 32'(r_r));
  assign c_partial = !cls_out_r && !cls_full_r;
  assign c_leaf    = (cur_lo_r == cur_hi_r);
  assign pe        = pend_rd_r + cur_carry_r;
  assign new_sum   = osum_r + d_r * SUM_W'(cur_len);
  assign at_root   = (lvl_r == '0);
  assign par_i     = LV_W'(lvl_r - LV_W'(1));
  assign acc_sum   = stk_acc_r[par_i] + ret_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_left > in_right) || (32'(in_right) >= n_eff)) state_nxt = ST_DONE;
          else state_nxt = ST_VISIT;
        end
      end
      ST_VISIT: state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_APPLY;
      ST_APPLY: begin
        if (c_partial) state_nxt = ST_VISIT;
        else if (!c_leaf && d_r != '0) state_nxt = ST_CRD0;
        else state_nxt = ST_RET;
      end
      ST_CRD0: state_nxt = ST_CRD1;
      ST_CRD1: state_nxt = ST_CWR1;
      ST_CWR1: state_nxt = ST_RET;
      ST_RET: begin
        if (at_root) state_nxt = ST_DONE;
        else if (!stk_right_r[par_i]) state_nxt = ST_VISIT;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory and stack controls
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    mode_nxt      = mode_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    v_nxt         = v_r;
    cur_k_nxt     = cur_k_r;
    cur_lo_nxt    = cur_lo_r;
    cur_hi_nxt    = cur_hi_r;
    cur_carry_nxt = cur_carry_r;
    lvl_nxt       = lvl_r;
    cls_out_nxt   = cls_out_r;
    cls_full_nxt  = cls_full_r;
    d_nxt         = d_r;
    osum_nxt      = osum_r;
    ret_nxt       = ret_r;
    res_sum_nxt   = res_sum_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    sum_we        = 1'b0;
    pend_we       = 1'b0;
    sum_wa        = cur_k_r;
    pend_wa       = cur_k_r;
    sum_wd        = '0;
    pend_wd       = '0;
    sum_ra        = cur_k_r;
    pend_ra       = cur_k_r;
    stk_push      = 1'b0;
    stk_upd       = 1'b0;
    stk_wi        = lvl_r;
    stk_upd_acc   = acc_sum;

    // Drop the output once taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // Zero one entry of each RAM per cycle
        sum_we      = 1'b1;
        pend_we     = 1'b1;
        sum_wa      = clr_cnt_r;
        pend_wa     = clr_cnt_r;
        clr_cnt_nxt = AW'(clr_cnt_r + AW'(1));
      end
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt      = in_tuser;
          l_nxt         = in_left;
          r_nxt         = in_right;
          v_nxt         = {{(SUM_W-VAL_W){in_value[VAL_W-1]}}, in_value};
          cur_k_nxt     = AW'(1);
          cur_lo_nxt    = '0;
          cur_hi_nxt    = IDX_W'(n_eff - 32'd1);
          cur_carry_nxt = '0;
          lvl_nxt       = '0;
          res_sum_nxt   = '0;
          res_err_nxt   = (in_left > in_right) || (32'(in_right) >= n_eff);
        end
      end
      ST_CALC: begin
        // Settle: fold the carried push into the stored pending add
        cls_out_nxt  = c_out;
        cls_full_nxt = c_full;
        osum_nxt     = sum_rd_r;
        d_nxt        = (c_full && mode_r == MODE_ADD) ? pe + v_r : pe;
      end
      ST_APPLY: begin
        sum_we  = 1'b1;
        sum_wd  = new_sum;
        pend_we = 1'b1;
        pend_wd = '0;
        if (mode_r == MODE_ADD) ret_nxt = new_sum;
        else ret_nxt = cls_full_r ? new_sum : '0;
        if (c_partial) begin
          // Descend left, carrying the pushed pending add
          stk_push      = 1'b1;
          cur_k_nxt     = AW'({cur_k_r, 1'b0});
          cur_hi_nxt    = cur_mid;
          cur_carry_nxt = d_r;
          lvl_nxt       = LV_W'(lvl_r + LV_W'(1));
        end
      end
      ST_CRD0: begin
        pend_ra = AW'({cur_k_r, 1'b0});
      end
      ST_CRD1: begin
        pend_ra = AW'({cur_k_r, 1'b1});
        pend_we = 1'b1;
        pend_wa = AW'({cur_k_r, 1'b0});
        pend_wd = pend_rd_r + d_r;
      end
      ST_CWR1: begin
        pend_we = 1'b1;
        pend_wa = AW'({cur_k_r, 1'b1});
        pend_wd = pend_rd_r + d_r;
      end
      ST_RET: begin
        if (at_root) begin
          res_sum_nxt = (mode_r == MODE_SUM) ? ret_r : '0;
        end else if (!stk_right_r[par_i]) begin
          // Left subtree done: record it, advance to the right child
          stk_upd       = 1'b1;
          stk_wi        = par_i;
          cur_k_nxt     = AW'({stk_k_r[par_i][AW-2:0], 1'b1});
          cur_lo_nxt    = IDX_W'(({1'b0, stk_lo_r[par_i]} + {1'b0, stk_hi_r[par_i]}
                                  + LEN_W'(2)) >> 1);
          cur_hi_nxt    = stk_hi_r[par_i];
          cur_carry_nxt = stk_carry_r[par_i];
        end else begin
          // Both children done: rebuild the parent sum in add mode
          if (mode_r == MODE_ADD) begin
            sum_we = 1'b1;
            sum_wa = stk_k_r[par_i];
            sum_wd = acc_sum;
          end
          ret_nxt = acc_sum;
          lvl_nxt = par_i;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = res_sum_r;
          out_err_nxt   = res_err_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Node sum RAM
  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd_r <= sum_mem[sum_ra];
  end

  // Pending add RAM
  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd_r <= pend_mem[pend_ra];
  end

  // Frame stack
  always_ff @(posedge clk) begin
    if (stk_push) begin
      stk_k_r[stk_wi]     <= cur_k_r;
      stk_lo_r[stk_wi]    <= cur_lo_r;
      stk_hi_r[stk_wi]    <= cur_hi_r;
      stk_carry_r[stk_wi] <= d_r;
      stk_acc_r[stk_wi]   <= '0;
      stk_right_r[stk_wi] <= 1'b0;
    end else if (stk_upd) begin
      stk_acc_r[stk_wi]   <= stk_upd_acc;
      stk_right_r[stk_wi] <= 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= CNT_RESET;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) cnt_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    v_r         <= v_nxt;
    cur_k_r     <= cur_k_nxt;
    cur_lo_r    <= cur_lo_nxt;
    cur_hi_r    <= cur_hi_nxt;
    cur_carry_r <= cur_carry_nxt;
    cls_out_r   <= cls_out_nxt;
    cls_full_r  <= cls_full_nxt;
    d_r         <= d_nxt;
    osum_r      <= osum_nxt;
    ret_r       <= ret_nxt;
    res_sum_r   <= res_sum_nxt;
    res_err_r   <= res_err_nxt;
    out_sum_r   <= out_sum_nxt;
    out_err_r   <= out_err_nxt;
  end

  // Checks
  `LSTS_ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_tready)
  `LSTS_ASSERT_SAME(a_error_zero_sum, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  `LSTS_ASSERT_NEXT(a_root_return_done, clk, rst_n, state_r == ST_RET && lvl_r == '0,
                    state_r == ST_DONE)
  `LSTS_ASSERT_NEXT(a_out_held, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))

endmodule

`default_nettype wire
